// ----- src/mbet_pkg.sv -----
`default_nettype none
package mbet_pkg;

    localparam int FRAC_BITS_DEF  = 24;
    localparam int COORD_BITS_DEF = 10;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int ITER_W     = 8;
    localparam int CNT_W      = ITER_W + 1;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_CENTER_X       = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_CENTER_Y       = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_STEP_SCALE     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_ESCAPE_LIMIT   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_ITERATIONS = 3'd4;

    localparam logic [31:0]       RST_CENTER_X       = 32'd0;
    localparam logic [31:0]       RST_CENTER_Y       = 32'd0;
    localparam logic [30:0]       RST_STEP_SCALE     = 31'd66940;
    localparam logic [3:0]        RST_ESCAPE_LIMIT   = 4'd2;
    localparam logic [ITER_W-1:0] RST_MAX_ITERATIONS = 8'd255;

    typedef struct packed {
        logic [31:0]       center_x;
        logic [31:0]       center_y;
        logic [30:0]       step_scale;
        logic [3:0]        escape_limit;
        logic [ITER_W-1:0] max_iterations;
    } t_cfg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAP_MUL,
        S_MAP_ADD,
        S_SQ_MUL,
        S_STEP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load_in;
        logic map_mul;
        logic map_add;
        logic sq_mul;
        logic step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic iter_done;
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

// ----- src/mandelbrot_escape_time_unit.sv -----
`default_nettype none
// Mandelbrot escape-time unit. Each input beat carries a signed pixel offset that is
// mapped to c = center + offset * step_scale (Q8.24, saturated), then z = z*z + c is
// iterated from z = c until |z|^2 exceeds escape_limit or the pass count passes
// max_iterations. One pixel is in flight at a time. A pixel also ends when z leaves the
// +-4 box. The squared magnitude test runs on the squares formed for the following
// pass. Each pass goes through the three 32x32 complex-square multipliers and then
// through the add and escape test. The result sits in an output register, so the next
// input beat is taken while it waits. Registers are to be written only while idle;
// the user is bound to this, and the block itself does not enforce it.
module mandelbrot_escape_time_unit #(
    parameter int FRAC_BITS  = mbet_pkg::FRAC_BITS_DEF,
    parameter int COORD_BITS = mbet_pkg::COORD_BITS_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_wr_en,
    input  wire logic [mbet_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  wire logic [mbet_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // pixel_x, pixel_y, zero pad
    input  wire logic [((2*COORD_BITS+7)/8)*8-1:0]    s_axis_tdata,
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // out_x, out_y, iteration_count, zero pad
    output logic [((2*COORD_BITS+mbet_pkg::ITER_W+7)/8)*8-1:0] m_axis_tdata,
    // in_set
    output logic [0:0]                                m_axis_tuser
);

    localparam int OUT_USED = 2 * COORD_BITS + mbet_pkg::ITER_W;
    localparam int OUT_W    = ((OUT_USED + 7) / 8) * 8;

    mbet_pkg::t_cfg    w_cfg;
    mbet_pkg::t_cmd    w_cmd;
    mbet_pkg::t_status w_status;

    logic signed [COORD_BITS-1:0]      w_out_x, w_out_y;
    logic [mbet_pkg::ITER_W-1:0]       w_count;
    logic                              w_in_set;

    mbet_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    mbet_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    mbet_dpath #(
        .FRAC_BITS  (FRAC_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (w_cfg),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .i_pixel_x         ($signed(s_axis_tdata[COORD_BITS-1:0])),
        .i_pixel_y         ($signed(s_axis_tdata[2*COORD_BITS-1:COORD_BITS])),
        .i_out_ready       (m_axis_tready),
        .o_out_valid       (m_axis_tvalid),
        .o_out_x           (w_out_x),
        .o_out_y           (w_out_y),
        .o_iteration_count (w_count),
        .o_in_set          (w_in_set)
    );

    assign m_axis_tdata = OUT_W'({w_count, w_out_y, w_out_x});
    assign m_axis_tuser = w_in_set;

endmodule
`default_nettype wire

// ----- src/mbet_cfg_regs.sv -----
`default_nettype none
module mbet_cfg_regs (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [mbet_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire logic [mbet_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    output mbet_pkg::t_cfg                        o_cfg
);

    mbet_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_x       <= mbet_pkg::RST_CENTER_X;
            r_cfg.center_y       <= mbet_pkg::RST_CENTER_Y;
            r_cfg.step_scale     <= mbet_pkg::RST_STEP_SCALE;
            r_cfg.escape_limit   <= mbet_pkg::RST_ESCAPE_LIMIT;
            r_cfg.max_iterations <= mbet_pkg::RST_MAX_ITERATIONS;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                mbet_pkg::CFG_CENTER_X:       r_cfg.center_x <= i_cfg_wdata;
                mbet_pkg::CFG_CENTER_Y:       r_cfg.center_y <= i_cfg_wdata;
                mbet_pkg::CFG_STEP_SCALE:     r_cfg.step_scale <= i_cfg_wdata[30:0];
                mbet_pkg::CFG_ESCAPE_LIMIT:   r_cfg.escape_limit <= i_cfg_wdata[3:0];
                mbet_pkg::CFG_MAX_ITERATIONS: begin
                    r_cfg.max_iterations <= i_cfg_wdata[mbet_pkg::ITER_W-1:0];
                end
                default: begin
                    // unknown index: drop the write
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// ----- src/mbet_ctrl.sv -----
`default_nettype none
module mbet_ctrl (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire mbet_pkg::t_status i_status,
    output mbet_pkg::t_cmd   o_cmd
);

    mbet_pkg::t_state r_state;
    mbet_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mbet_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mbet_pkg::S_IDLE:    if (i_in_valid) n_state = mbet_pkg::S_MAP_MUL;
            mbet_pkg::S_MAP_MUL: n_state = mbet_pkg::S_MAP_ADD;
            mbet_pkg::S_MAP_ADD: n_state = mbet_pkg::S_SQ_MUL;
            mbet_pkg::S_SQ_MUL:  n_state = mbet_pkg::S_STEP;
            mbet_pkg::S_STEP: begin
                n_state = i_status.iter_done ? mbet_pkg::S_DONE : mbet_pkg::S_SQ_MUL;
            end
            mbet_pkg::S_DONE:    if (i_status.out_free) n_state = mbet_pkg::S_IDLE;
            default:             n_state = mbet_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready       = (r_state == mbet_pkg::S_IDLE);
        o_cmd.load_in    = (r_state == mbet_pkg::S_IDLE) && i_in_valid;
        o_cmd.map_mul    = (r_state == mbet_pkg::S_MAP_MUL);
        o_cmd.map_add    = (r_state == mbet_pkg::S_MAP_ADD);
        o_cmd.sq_mul     = (r_state == mbet_pkg::S_SQ_MUL);
        o_cmd.step       = (r_state == mbet_pkg::S_STEP);
        o_cmd.load_out   = (r_state == mbet_pkg::S_DONE) && i_status.out_free;
    end

endmodule
`default_nettype wire

// ----- src/mbet_dpath.sv -----
`default_nettype none
module mbet_dpath #(
    parameter int FRAC_BITS  = mbet_pkg::FRAC_BITS_DEF,
    parameter int COORD_BITS = mbet_pkg::COORD_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire mbet_pkg::t_cfg                 i_cfg,
    input  wire mbet_pkg::t_cmd                 i_cmd,
    output mbet_pkg::t_status                   o_status,
    input  wire logic signed [COORD_BITS-1:0]   i_pixel_x,
    input  wire logic signed [COORD_BITS-1:0]   i_pixel_y,
    input  wire logic                           i_out_ready,
    output logic                                o_out_valid,
    output logic signed [COORD_BITS-1:0]        o_out_x,
    output logic signed [COORD_BITS-1:0]        o_out_y,
    output logic [mbet_pkg::ITER_W-1:0]         o_iteration_count,
    output logic                                o_in_set
);

    localparam int PROD_W = COORD_BITS + 32;
    localparam int SUM_W  = PROD_W + 1;
    localparam logic signed [63:0] BOUND   = 64'sd4 <<< FRAC_BITS;
    localparam logic signed [31:0] BOUND32 = 32'sd4 <<< FRAC_BITS;

    logic signed [COORD_BITS-1:0] r_px, r_py;
    logic signed [PROD_W-1:0]     r_prod_x, r_prod_y;
    logic signed [31:0]           r_cre, r_cim, r_zre, r_zim;
    logic signed [63:0]           r_prr, r_pii, r_pri;
    logic [mbet_pkg::CNT_W-1:0]   r_count;
    logic                         r_first;
    logic [mbet_pkg::ITER_W-1:0]  r_res_count;
    logic                         r_res_in_set;

    logic                         r_out_valid;
    logic signed [COORD_BITS-1:0] r_out_x, r_out_y;
    logic [mbet_pkg::ITER_W-1:0]  r_out_count;
    logic                         r_out_in_set;

    logic signed [SUM_W-1:0]      w_map_x, w_map_y;
    logic signed [63:0]           w_nre, w_nim;
    logic [63:0]                  w_sum_sq, w_lim;
    logic [mbet_pkg::CNT_W-1:0]   n_count;
    logic                         w_esc_sq, w_cap, w_out_bound;

    function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
        logic hi_all, hi_any;
        hi_all = &v[SUM_W-1:31];
        hi_any = |v[SUM_W-1:31];
        if (hi_all || !hi_any) begin
            sat32 = v[31:0];
        end else if (v[SUM_W-1]) begin
            sat32 = 32'sh8000_0000;
        end else begin
            sat32 = 32'sh7fff_ffff;
        end
    endfunction

    // pixel to plane point
    assign w_map_x = SUM_W'(r_prod_x) + SUM_W'($signed(i_cfg.center_x));
    assign w_map_y = SUM_W'(r_prod_y) + SUM_W'($signed(i_cfg.center_y));

    // one pass: floor shifts are arithmetic right shifts
    assign w_nre = (r_prr >>> FRAC_BITS) - (r_pii >>> FRAC_BITS) + 64'(r_cre);
    assign w_nim = (r_pri >>> (FRAC_BITS - 1)) + 64'(r_cim);

    // squares of the current z double as the magnitude test of the previous pass
    assign w_sum_sq = $unsigned(r_prr) + $unsigned(r_pii);
    assign w_lim    = 64'(i_cfg.escape_limit) << (2 * FRAC_BITS);
    assign w_esc_sq = !r_first && (w_sum_sq > w_lim);

    assign n_count     = r_count + mbet_pkg::CNT_W'(1);
    assign w_cap       = n_count > {1'b0, i_cfg.max_iterations};
    assign w_out_bound = (w_nre >= BOUND) || (w_nre <= -BOUND) ||
                         (w_nim >= BOUND) || (w_nim <= -BOUND);

    assign o_status.iter_done = w_esc_sq || w_cap || w_out_bound;
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_px <= i_pixel_x;
            r_py <= i_pixel_y;
        end
        if (i_cmd.map_mul) begin
            r_prod_x <= r_px * $signed({1'b0, i_cfg.step_scale});
            r_prod_y <= r_py * $signed({1'b0, i_cfg.step_scale});
        end
        if (i_cmd.map_add) begin
            r_cre   <= sat32(w_map_x);
            r_cim   <= sat32(w_map_y);
            r_zre   <= sat32(w_map_x);
            r_zim   <= sat32(w_map_y);
            r_count <= '0;
            r_first <= 1'b1;
        end
        if (i_cmd.sq_mul) begin
            r_prr <= r_zre * r_zre;
            r_pii <= r_zim * r_zim;
            r_pri <= r_zre * r_zim;
        end
        if (i_cmd.step) begin
            if (w_esc_sq) begin
                r_res_count  <= r_count[mbet_pkg::ITER_W-1:0];
                r_res_in_set <= 1'b0;
            end else begin
                r_count <= n_count;
                priority if (w_cap) begin
                    r_res_count  <= '0;
                    r_res_in_set <= 1'b1;
                end else if (w_out_bound) begin
                    r_res_count  <= n_count[mbet_pkg::ITER_W-1:0];
                    r_res_in_set <= 1'b0;
                end else begin
                    r_zre   <= w_nre[31:0];
                    r_zim   <= w_nim[31:0];
                    r_first <= 1'b0;
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_x      <= r_px;
            r_out_y      <= r_py;
            r_out_count  <= r_res_count;
            r_out_in_set <= r_res_in_set;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_x           = r_out_x;
    assign o_out_y           = r_out_y;
    assign o_iteration_count = r_out_count;
    assign o_in_set          = r_out_in_set;

`ifndef NO_ASSERTIONS
    a_in_set_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_in_set) |-> (r_out_count == '0))
        else $error("in-set result with nonzero count");

    a_escape_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_in_set) |-> (r_out_count != '0))
        else $error("escaped result with zero count");

    a_z_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && !o_status.iter_done) |=> ((r_zre < BOUND32) && (r_zre > -BOUND32) &&
                                                (r_zim < BOUND32) && (r_zim > -BOUND32)))
        else $error("z left the escape bound without ending the pixel");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !i_cmd.load_out)
        else $error("output register overwritten while held");
`endif

endmodule
`default_nettype wire
